FILE: rtl/wvsd_pkg.sv
package wvsd_pkg;

  localparam int PRESHIFT = 20;

  localparam logic [31:0] ANG_90 = 32'd589824000;
  localparam logic [31:0] ANG_180 = 32'd1179648000;
  localparam logic [31:0] ANG_360 = 32'd2359296000;
  localparam logic [31:0] ANG_HALF_LSB = 32'd32768;

  localparam logic [15:0] DIR_NORTH = 16'd36000;

  localparam int NORM_BITS = 30;
  localparam int NORM_STEPS = 5;

  localparam int QW = 29;
  localparam logic [QW-1:0] RAD_TO_ANG = 29'd375493620;

  typedef struct packed {
    logic miss;
    logic calm;
    logic xneg;
    logic yneg;
    logic last;
  } side_t;

  typedef struct packed {
    logic              neg;
    logic signed [31:0] z;
  } ang_t;

  function automatic logic [31:0] atan_entry(input int idx);
    logic [31:0] val;
    case (idx)
      0: val = 32'd294912000;
      1: val = 32'd174096719;
      2: val = 32'd91987925;
      3: val = 32'd46694507;
      4: val = 32'd23437865;
      5: val = 32'd11730358;
      6: val = 32'd5866610;
      7: val = 32'd2933484;
      8: val = 32'd1466764;
      9: val = 32'd733385;
      10: val = 32'd366693;
      11: val = 32'd183346;
      12: val = 32'd91673;
      13: val = 32'd45837;
      14: val = 32'd22918;
      15: val = 32'd11459;
      16: val = 32'd5730;
      17: val = 32'd2865;
      18: val = 32'd1432;
      19: val = 32'd716;
      20: val = 32'd358;
      21: val = 32'd179;
      22: val = 32'd90;
      23: val = 32'd45;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

FILE: rtl/wvsd_cordic_cell.sv
module wvsd_cordic_cell #(
  parameter int XW    = 39,
  parameter int STAGE = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [31:0]   z_in,
  output logic signed [XW-1:0] x_r,
  output logic signed [XW-1:0] y_r,
  output logic signed [31:0]   z_r
);

  localparam logic signed [31:0] ATAN = wvsd_pkg::atan_entry(STAGE);

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [XW-1:0] x_nxt;
  logic signed [XW-1:0] y_nxt;
  logic signed [31:0]   z_nxt;

  always_comb begin
    xs = x_in >>> STAGE;
    ys = y_in >>> STAGE;
    if (!y_in[XW-1]) begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + ATAN;
    end else begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

endmodule

FILE: rtl/wvsd_norm_cell.sv
module wvsd_norm_cell #(
  parameter int MW = 38,
  parameter int SH = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [MW-1:0] mx_in,
  input  logic [MW-1:0] my_in,
  output logic [MW-1:0] mx_r,
  output logic [MW-1:0] my_r
);

  logic          big;
  logic [MW-1:0] mx_nxt;
  logic [MW-1:0] my_nxt;

  always_comb begin
    big    = 64'(mx_in) >= (64'd1 << (wvsd_pkg::NORM_BITS + SH - 1));
    mx_nxt = big ? (mx_in >> SH) : mx_in;
    my_nxt = big ? (my_in >> SH) : my_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r <= mx_nxt;
      my_r <= my_nxt;
    end
  end

endmodule

FILE: rtl/wvsd_div_cell.sv
module wvsd_div_cell (
  input  logic                          clk,
  input  logic                          en,
  input  logic [wvsd_pkg::NORM_BITS-1:0] rem_in,
  input  logic [wvsd_pkg::QW-1:0]        nq_in,
  input  logic [wvsd_pkg::NORM_BITS-1:0] d_in,
  output logic [wvsd_pkg::NORM_BITS-1:0] rem_r,
  output logic [wvsd_pkg::QW-1:0]        nq_r,
  output logic [wvsd_pkg::NORM_BITS-1:0] d_r
);

  localparam int DW = wvsd_pkg::NORM_BITS;
  localparam int QW = wvsd_pkg::QW;

  logic [DW:0]   r2;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_nxt;
  logic [QW-1:0] nq_nxt;

  // The remainder stays below the divisor, so the shifted trial fits in DW+1 bits.
  always_comb begin
    r2      = {rem_in, nq_in[QW-1]};
    ge      = r2 >= {1'b0, d_in};
    diff    = r2 - {1'b0, d_in};
    rem_nxt = ge ? diff[DW-1:0] : r2[DW-1:0];
    nq_nxt  = {nq_in[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      nq_r  <= nq_nxt;
      d_r   <= d_in;
    end
  end

endmodule

FILE: rtl/wvsd_sqrt_cell.sv
module wvsd_sqrt_cell #(
  parameter int NW = 32,
  parameter int K  = 15
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] op_in,
  input  logic [NW-1:0] res_in,
  output logic [NW-1:0] op_r,
  output logic [NW-1:0] res_r
);

  localparam logic [NW-1:0] ONE = {{(NW-1){1'b0}}, 1'b1} << (2 * K);

  logic [NW:0]   trial;
  logic          ge;
  logic [NW-1:0] op_nxt;
  logic [NW-1:0] res_nxt;

  always_comb begin
    trial   = {1'b0, res_in} + {1'b0, ONE};
    ge      = {1'b0, op_in} >= trial;
    op_nxt  = ge ? (op_in - trial[NW-1:0]) : op_in;
    res_nxt = ge ? ((res_in >> 1) + ONE) : (res_in >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r  <= op_nxt;
      res_r <= res_nxt;
    end
  end

endmodule

FILE: rtl/wind_vector_to_speed_direction_top.sv
// Wind vector to speed and direction.
// One word on the input stream carries the u and v components of one grid point, two's
// complement in 0.01 m/s, with a missing flag for each in in_tuser and the end-of-grid mark
// on in_tlast. One word on the output stream carries the speed in 0.01 m/s and the direction
// the wind comes from in 0.01 degree, in the range 1 to 36000; calm gives direction 0. When
// either component is missing, out_tuser is set and speed and direction are zero. out_tlast
// repeats in_tlast of the same point.
// The block is a chain of registered cells: CORDIC rotations for the angle, a normalizer
// and a bit-per-cell divider for the residual angle, and a bit-per-cell square root in
// parallel for the speed. One word is accepted every cycle while in_tready is high, since
// every cell is its own register stage.
// When the receiver stalls, the result waits in the output register and the chain keeps
// advancing as long as its last stage is empty; only when a finished word is held behind the
// stalled output does in_tready drop. Reset empties the chain and the output register and
// leaves in_tready high.
module wind_vector_to_speed_direction_top #(
  parameter int CORDIC_STAGES   = 16,
  parameter int COMPONENT_WIDTH = 16
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  // u_component, v_component
  input  logic [((2*COMPONENT_WIDTH+7)/8)*8-1:0]      in_tdata,
  // u_missing, v_missing
  input  logic [1:0]                                  in_tuser,
  input  logic                                        in_tlast,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  // speed, direction
  output logic [31:0]                                 out_tdata,
  // result_missing
  output logic                                        out_tuser,
  output logic                                        out_tlast
);

  localparam int W       = COMPONENT_WIDTH;
  localparam int S       = CORDIC_STAGES;
  localparam int XW      = W + 23;
  localparam int MW      = XW - 1;
  localparam int NW      = 2 * W;
  localparam int QW      = wvsd_pkg::QW;
  localparam int DW      = wvsd_pkg::NORM_BITS;
  localparam int NS      = wvsd_pkg::NORM_STEPS;
  localparam int NUMW    = DW + QW;
  localparam int ST_PREP = S + 1;
  localparam int ST_MUL  = ST_PREP + NS + 1;
  localparam int ST_DIV  = ST_MUL + QW;
  localparam int LAST    = ST_DIV + 1;
  localparam int ST_SPD  = W + 3;

  localparam logic [31:0] C_Q1  = wvsd_pkg::ANG_HALF_LSB;
  localparam logic [31:0] C_Q23 = wvsd_pkg::ANG_180 + wvsd_pkg::ANG_HALF_LSB;
  localparam logic [31:0] C_Q4  = wvsd_pkg::ANG_360 + wvsd_pkg::ANG_HALF_LSB;

  logic out_free;
  logic adv;

  logic [LAST:0]         vld_r;
  wvsd_pkg::side_t       side_r [0:LAST];
  wvsd_pkg::side_t       side0;

  logic signed [W-1:0]   u_raw;
  logic signed [W-1:0]   v_raw;
  logic [W-1:0]          au;
  logic [W-1:0]          av;
  logic [W-1:0]          au_r;
  logic [W-1:0]          av_r;

  logic [NW-1:0]         squ_r;
  logic [NW-1:0]         sqv_r;
  logic [NW-1:0]         n_r;
  logic [NW-1:0]         op_w  [0:W];
  logic [NW-1:0]         res_w [0:W];
  logic [W:0]            root_rnd;
  logic [15:0]           spd_r [ST_SPD:LAST];

  logic signed [XW-1:0]  cx [0:S];
  logic signed [XW-1:0]  cy [0:S];
  logic signed [31:0]    cz [0:S];

  logic signed [XW-1:0]  yabs;
  logic [MW-1:0]         pmx_r;
  logic [MW-1:0]         pmy_r;
  wvsd_pkg::ang_t        ang_r [ST_PREP:ST_DIV];
  logic [MW-1:0]         nmx [0:NS];
  logic [MW-1:0]         nmy [0:NS];

  logic [MW-1:0]         myc;
  logic [DW-1:0]         dmx_r;
  logic [NUMW-1:0]       num_r;
  logic [DW-1:0]         drem [0:QW];
  logic [QW-1:0]         dnq  [0:QW];
  logic [DW-1:0]         dd   [0:QW];

  logic signed [31:0]    corr_s;
  logic signed [31:0]    zc;
  logic [29:0]           phi_nxt;
  logic [29:0]           phi_r;

  wvsd_pkg::side_t       sd;
  logic [31:0]           phi32;
  logic [31:0]           rsum;
  logic [15:0]           dir_nxt;
  logic [15:0]           speed_nxt;

  logic                  out_valid_r;
  logic [31:0]           out_data_r;
  logic                  out_miss_r;
  logic                  out_last_r;

  assign out_free  = !out_valid_r || out_tready;
  assign adv       = out_free || !vld_r[LAST];
  assign in_tready = adv;

  always_comb begin
    u_raw      = in_tdata[W-1:0];
    v_raw      = in_tdata[2*W-1:W];
    au         = u_raw[W-1] ? (-u_raw) : u_raw;
    av         = v_raw[W-1] ? (-v_raw) : v_raw;
    side0.miss = in_tuser[0] | in_tuser[1];
    side0.calm = (u_raw == '0) && (v_raw == '0);
    side0.xneg = !v_raw[W-1] && (v_raw != '0);
    side0.yneg = !u_raw[W-1] && (u_raw != '0);
    side0.last = in_tlast;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAST-1:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side0;
      for (int k = 1; k <= LAST; k++) begin
        side_r[k] <= side_r[k-1];
      end
      au_r <= au;
      av_r <= av;
    end
  end

  // Speed: squares, sum, one root bit per cell, then round to nearest.
  always_ff @(posedge clk) begin
    if (adv) begin
      squ_r <= NW'(au_r) * NW'(au_r);
      sqv_r <= NW'(av_r) * NW'(av_r);
      n_r   <= squ_r + sqv_r;
    end
  end

  assign op_w[0]  = n_r;
  assign res_w[0] = '0;

  for (genvar c = 0; c < W; c++) begin : g_sqrt
    wvsd_sqrt_cell #(.NW(NW), .K(W - 1 - c)) u_cell (
      .clk    (clk),
      .en     (adv),
      .op_in  (op_w[c]),
      .res_in (res_w[c]),
      .op_r   (op_w[c+1]),
      .res_r  (res_w[c+1])
    );
  end

  always_comb begin
    root_rnd = {1'b0, res_w[W][W-1:0]} + {{W{1'b0}}, (op_w[W] > res_w[W])};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      spd_r[ST_SPD] <= 16'(root_rnd);
      for (int k = ST_SPD + 1; k <= LAST; k++) begin
        spd_r[k] <= spd_r[k-1];
      end
    end
  end

  // Direction: CORDIC vectoring on (|v|, |u|).
  assign cx[0] = $signed(XW'(av_r) << wvsd_pkg::PRESHIFT);
  assign cy[0] = $signed(XW'(au_r) << wvsd_pkg::PRESHIFT);
  assign cz[0] = '0;

  for (genvar i = 0; i < S; i++) begin : g_cordic
    wvsd_cordic_cell #(.XW(XW), .STAGE(i)) u_cell (
      .clk  (clk),
      .en   (adv),
      .x_in (cx[i]),
      .y_in (cy[i]),
      .z_in (cz[i]),
      .x_r  (cx[i+1]),
      .y_r  (cy[i+1]),
      .z_r  (cz[i+1])
    );
  end

  always_comb begin
    yabs = cy[S][XW-1] ? (-cy[S]) : cy[S];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ang_r[ST_PREP].neg <= cy[S][XW-1];
      ang_r[ST_PREP].z   <= cz[S];
      for (int k = ST_PREP + 1; k <= ST_DIV; k++) begin
        ang_r[k] <= ang_r[k-1];
      end
      pmy_r <= yabs[MW-1:0];
      if (!cx[S][XW-1] && (cx[S] != '0)) begin
        pmx_r <= cx[S][MW-1:0];
      end else begin
        pmx_r <= {{(MW-1){1'b0}}, 1'b1};
      end
    end
  end

  assign nmx[0] = pmx_r;
  assign nmy[0] = pmy_r;

  for (genvar j = 0; j < NS; j++) begin : g_norm
    wvsd_norm_cell #(.MW(MW), .SH(1 << (NS - 1 - j))) u_cell (
      .clk   (clk),
      .en    (adv),
      .mx_in (nmx[j]),
      .my_in (nmy[j]),
      .mx_r  (nmx[j+1]),
      .my_r  (nmy[j+1])
    );
  end

  always_comb begin
    myc = (nmy[NS] > nmx[NS]) ? nmx[NS] : nmy[NS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r <= NUMW'(myc[DW-1:0]) * NUMW'(wvsd_pkg::RAD_TO_ANG);
      dmx_r <= nmx[NS][DW-1:0];
    end
  end

  assign drem[0] = num_r[NUMW-1:QW];
  assign dnq[0]  = num_r[QW-1:0];
  assign dd[0]   = dmx_r;

  for (genvar t = 0; t < QW; t++) begin : g_div
    wvsd_div_cell u_cell (
      .clk    (clk),
      .en     (adv),
      .rem_in (drem[t]),
      .nq_in  (dnq[t]),
      .d_in   (dd[t]),
      .rem_r  (drem[t+1]),
      .nq_r   (dnq[t+1]),
      .d_r    (dd[t+1])
    );
  end

  always_comb begin
    corr_s = $signed(32'(dnq[QW]));
    if (ang_r[ST_DIV].neg) begin
      zc = ang_r[ST_DIV].z - corr_s;
    end else begin
      zc = ang_r[ST_DIV].z + corr_s;
    end
    if (zc[31]) begin
      phi_nxt = '0;
    end else if ($unsigned(zc) > wvsd_pkg::ANG_90) begin
      phi_nxt = wvsd_pkg::ANG_90[29:0];
    end else begin
      phi_nxt = zc[29:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      phi_r <= phi_nxt;
    end
  end

  always_comb begin
    sd    = side_r[LAST];
    phi32 = {2'b00, phi_r};
    case ({sd.xneg, sd.yneg})
      2'b00: rsum = C_Q1 + phi32;
      2'b10: rsum = C_Q23 - phi32;
      2'b11: rsum = C_Q23 + phi32;
      default: rsum = C_Q4 - phi32;
    endcase
    dir_nxt = rsum[31:16];
    if ((dir_nxt == '0) || (dir_nxt > wvsd_pkg::DIR_NORTH)) begin
      dir_nxt = wvsd_pkg::DIR_NORTH;
    end
    speed_nxt = spd_r[LAST];
    if (sd.miss || sd.calm) begin
      dir_nxt   = '0;
      speed_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= vld_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= {dir_nxt, speed_nxt};
      out_miss_r <= sd.miss;
      out_last_r <= sd.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_miss_r;
  assign out_tlast  = out_last_r;

  a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("missing result carries nonzero speed or direction");

  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser && (out_tdata[15:0] != '0)) |->
      ((out_tdata[31:16] != '0) && (out_tdata[31:16] <= wvsd_pkg::DIR_NORTH)))
    else $error("direction of a nonzero wind outside 1 to 36000");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (vld_r[LAST] && out_tvalid && !out_tready))
    else $error("input held off without a finished word behind a stalled output");

endmodule
